// ----- rtl/tkd_pkg.sv -----
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants for the touch key debounce and repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

    // Width of the internal time arithmetic (wraps modulo 2^TIME_BITS)
    localparam int TIME_BITS = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEYPAD_LOCK    = 2'd0;
    localparam logic [1:0] CFG_NONE_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_MS    = 2'd2;
    localparam logic [1:0] CFG_REPEAT_GAP_MS  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_NONE_THRESHOLD = 8'd13;
    localparam logic [7:0]  RST_DEBOUNCE_MS    = 8'd10;
    localparam logic [15:0] RST_REPEAT_GAP_MS  = 16'd250;

    // Channel code meaning "no code seen yet" or "no last key"
    localparam logic [7:0] CODE_NONE = 8'hFF;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic        keypad_lock;
        logic [7:0]  none_threshold;
        logic [7:0]  debounce_ms;
        logic [15:0] repeat_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  key_channel;
        logic        key_valid;
        logic [31:0] key_time;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/tkd_scan_if.sv -----
// ----------------------------------------------------------------------------
// tkd_scan_if
// Channel carrying one keypad scan item: time stamp and touched channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkd_scan_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [7:0]  touch_code;

    modport source (output valid, output now_ms, output touch_code, input ready);
    modport sink   (input valid, input now_ms, input touch_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/tkd_key_if.sv -----
// ----------------------------------------------------------------------------
// tkd_key_if
// Channel carrying one key state item per scan.
// ----------------------------------------------------------------------------
`default_nettype none

interface tkd_key_if;
    logic        valid;
    logic        ready;
    logic [7:0]  key_channel;
    logic        key_valid;
    logic [31:0] key_time;

    modport source (output valid, output key_channel, output key_valid,
                    output key_time, input ready);
    modport sink   (input valid, input key_channel, input key_valid,
                    input key_time, output ready);
endinterface

`default_nettype wire

// ----- rtl/tkd_cfg.sv -----
// ----------------------------------------------------------------------------
// tkd_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_cfg
    import tkd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEYPAD_LOCK:    cfg_next.keypad_lock    = cfg_data[0];
                CFG_NONE_THRESHOLD: cfg_next.none_threshold = cfg_data[7:0];
                CFG_DEBOUNCE_MS:    cfg_next.debounce_ms    = cfg_data[7:0];
                CFG_REPEAT_GAP_MS:  cfg_next.repeat_gap_ms  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keypad_lock    <= 1'b0;
            cfg_reg.none_threshold <= RST_NONE_THRESHOLD;
            cfg_reg.debounce_ms    <= RST_DEBOUNCE_MS;
            cfg_reg.repeat_gap_ms  <= RST_REPEAT_GAP_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/tkd_core.sv -----
// ----------------------------------------------------------------------------
// tkd_core
// Debounce and repeat lockout state; updates once per accepted scan item and
// presents the new key state as the result of that item.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_core
    import tkd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        take,
    input  wire logic [31:0] now_ms,
    input  wire logic [7:0]  touch_code,
    output res_t             res
);

    logic [7:0] prev_code_reg,    prev_code_next;
    time_t      down_start_reg,   down_start_next;
    time_t      up_start_reg,     up_start_next;
    logic [7:0] cur_channel_reg,  cur_channel_next;
    logic       cur_valid_reg,    cur_valid_next;
    time_t      cur_time_reg,     cur_time_next;
    logic [7:0] last_channel_reg, last_channel_next;
    time_t      last_time_reg,    last_time_next;

    time_t      now;
    logic [7:0] prev_eff;
    logic       touched;
    time_t      el_down;
    time_t      el_up;
    time_t      el_last;
    time_t      deb;
    time_t      gap;

    assign now      = time_t'(now_ms);
    assign prev_eff = (prev_code_reg == CODE_NONE) ? touch_code : prev_code_reg;
    assign touched  = touch_code < cfg.none_threshold;
    assign el_down  = now - down_start_reg;
    assign el_up    = now - up_start_reg;
    assign el_last  = now - last_time_reg;
    assign deb      = time_t'(cfg.debounce_ms);
    assign gap      = time_t'(cfg.repeat_gap_ms);

    // Work out the state after this scan
    always_comb
    begin
        prev_code_next    = prev_eff;
        down_start_next   = down_start_reg;
        up_start_next     = up_start_reg;
        cur_channel_next  = cur_channel_reg;
        cur_valid_next    = cur_valid_reg;
        cur_time_next     = cur_time_reg;
        last_channel_next = last_channel_reg;
        last_time_next    = last_time_reg;

        priority if (cfg.keypad_lock)
        begin
            // Locked: drop the key, track release start only
            cur_valid_next = 1'b0;
            if (touched)
            begin
                up_start_next = '0;
            end
            else
            begin
                down_start_next = '0;
                if (up_start_reg == '0)
                begin
                    up_start_next = now;
                end
            end
        end
        else if (touched)
        begin
            up_start_next = '0;
            if (touch_code != prev_eff)
            begin
                prev_code_next  = touch_code;
                down_start_next = now;
            end
            else if (down_start_reg != '0 && el_down > deb)
            begin
                down_start_next = '0;
                // Same key as the last one must wait out the repeat gap
                if (last_channel_reg != touch_code || el_last > gap)
                begin
                    cur_channel_next = touch_code;
                    cur_valid_next   = 1'b1;
                    cur_time_next    = now;
                end
            end
        end
        else
        begin
            down_start_next = '0;
            if (cur_time_reg == '0)
            begin
                cur_time_next = now;
            end
            if (touch_code != prev_eff)
            begin
                up_start_next  = now;
                prev_code_next = touch_code;
            end
            else if (up_start_reg != '0 && el_up > deb)
            begin
                // Release settled: save the key as the last one
                up_start_next     = '0;
                last_channel_next = cur_channel_reg;
                last_time_next    = cur_time_next;
                cur_valid_next    = 1'b0;
                cur_time_next     = now;
            end
        end
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg    <= CODE_NONE;
            down_start_reg   <= '0;
            up_start_reg     <= '0;
            cur_channel_reg  <= '0;
            cur_valid_reg    <= 1'b0;
            cur_time_reg     <= '0;
            last_channel_reg <= CODE_NONE;
            last_time_reg    <= '0;
        end
        else if (take)
        begin
            prev_code_reg    <= prev_code_next;
            down_start_reg   <= down_start_next;
            up_start_reg     <= up_start_next;
            cur_channel_reg  <= cur_channel_next;
            cur_valid_reg    <= cur_valid_next;
            cur_time_reg     <= cur_time_next;
            last_channel_reg <= last_channel_next;
            last_time_reg    <= last_time_next;
        end
    end

    // Result of this item is the new key state
    assign res.key_channel = cur_channel_next;
    assign res.key_valid   = cur_valid_next;
    assign res.key_time    = 32'(cur_time_next);

    // A locked scan always leaves the key cleared
    a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && cfg.keypad_lock |=> !cur_valid_reg)
        else $error("key valid after locked scan");

    // A touch never leaves release timing running
    a_touch_stops_up: assert property (@(posedge clk) disable iff (!rst_n)
        take && touched |=> up_start_reg == '0)
        else $error("release timer running after touch");

endmodule

`default_nettype wire

// ----- rtl/tkd_out_buf.sv -----
// ----------------------------------------------------------------------------
// tkd_out_buf
// Result register with a skid stage, so a new item is taken while the
// previous result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_out_buf
    import tkd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      can_push,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_data
);

    logic out_valid_reg,  out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg,   out_data_next;
    res_t skid_data_reg,  skid_data_next;
    logic pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    // Move items between input, skid and output stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item with the output empty");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("item lost on a stalled output");

    a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> out_valid_reg && !skid_valid_reg)
        else $error("skid item not moved to output");

endmodule

`default_nettype wire

// ----- rtl/touch_key_debounce_repeat.sv -----
// ----------------------------------------------------------------------------
// touch_key_debounce_repeat
// Touch keypad debounce with repeat lockout: one key state item per scan.
//
//   channel  direction  payload                              handshake
//   scan     in         now_ms[31:0], touch_code[7:0]        valid/ready
//   key      out        key_channel[7:0], key_valid,         valid/ready
//                       key_time[31:0]
//   cfg      in         cfg_index[1:0], cfg_data[15:0]       cfg_we only
//
// One scan item is taken per cycle while scan.ready is high; its result is
// registered in the output or skid stage. The state update for a scan is
// one pass of compares and 32-bit subtractions between the state registers.
// The output stage holds two results, so scan.ready drops only when the
// key side has stalled with both held. Reset clears all state and loads the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_key_debounce_repeat
    import tkd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    tkd_scan_if.sink         scan,
    tkd_key_if.source        key
);

    cfg_t cfg;
    res_t res;
    res_t out_data;
    logic take;
    logic can_push;
    logic out_valid;

    assign take       = scan.valid && can_push;
    assign scan.ready = can_push;

    // Configuration registers
    tkd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Debounce and lockout state
    tkd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .take       (take),
        .now_ms     (scan.now_ms),
        .touch_code (scan.touch_code),
        .res        (res)
    );

    // Result register and skid stage
    tkd_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (key.ready),
        .out_data  (out_data)
    );

    assign key.valid       = out_valid;
    assign key.key_channel = out_data.key_channel;
    assign key.key_valid   = out_data.key_valid;
    assign key.key_time    = out_data.key_time;

endmodule

`default_nettype wire

// ----- bench/touch_key_debounce_repeat_tb.sv -----
// ----------------------------------------------------------------------------
// touch_key_debounce_repeat_tb
// Self-checking bench for the touch key debounce and repeat lockout block.
// Scans are fed from a queue through a valid/ready driver. Each accepted scan
// updates a local copy of the keypad state, which yields the expected key
// item. A monitor compares every key item field by field, in order. The run
// moves through default, extreme, locked and random settings, with random idling on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
module touch_key_debounce_repeat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 33;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 80;
    localparam int CALM_FROM      = 500;
    localparam int CALM_TO        = 620;
    localparam int SETTLE_CYCLES  = 10;

    typedef struct {
        time_t      stamp;
        logic [7:0] code;
    } scan_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_KEYPAD_LOCK;
    logic [15:0] cfg_data = '0;

    tkd_scan_if scan_bus ();
    tkd_key_if  key_bus ();

    touch_key_debounce_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_bus),
        .key       (key_bus)
    );

    // Local copy of the settings and of the keypad state
    logic        kp_lock   = 1'b0;
    logic [7:0]  kp_thr    = RST_NONE_THRESHOLD;
    logic [7:0]  kp_deb    = RST_DEBOUNCE_MS;
    logic [15:0] kp_gap    = RST_REPEAT_GAP_MS;
    logic [7:0]  seen_code = CODE_NONE;
    time_t       press_t0  = '0;
    time_t       lift_t0   = '0;
    logic [7:0]  key_chan  = '0;
    logic        key_on    = 1'b0;
    time_t       key_t     = '0;
    logic [7:0]  last_ch   = CODE_NONE;
    time_t       last_t    = '0;

    scan_item_t pending_scans[$];
    res_t       key_expect_q[$];
    res_t       want;

    time_t      clock_ms = '0;
    logic [7:0] last_touch = '0;
    int         queued = 0;
    int         scans_taken = 0;
    int         results_taken = 0;
    int         keys_held = 0;
    int         mismatches = 0;
    int         settings_used = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         quiet_cycles = 0;

    // Advance the keypad state by one scan and queue the key item it yields
    function automatic void keypad_step(input time_t now, input logic [7:0] code);
        logic  touched;
        time_t since_press;
        time_t since_last;
        time_t since_lift;
        res_t  r;
        touched     = code < kp_thr;
        since_press = now - press_t0;
        since_last  = now - last_t;
        since_lift  = now - lift_t0;
        if (seen_code == CODE_NONE)
            seen_code = code;
        if (kp_lock)
        begin
            // locked: nothing accepted, only the release timer runs
            key_on = 1'b0;
            if (touched)
                lift_t0 = '0;
            else
            begin
                press_t0 = '0;
                if (lift_t0 == '0)
                    lift_t0 = now;
            end
        end
        else if (touched)
        begin
            lift_t0 = '0;
            if (code != seen_code)
            begin
                seen_code = code;
                press_t0  = now;
            end
            else if (press_t0 != '0 && since_press > time_t'(kp_deb))
            begin
                press_t0 = '0;
                // same channel as the last release waits out the repeat gap
                if (last_ch != code || since_last > time_t'(kp_gap))
                begin
                    key_chan = code;
                    key_on   = 1'b1;
                    key_t    = now;
                end
            end
        end
        else
        begin
            press_t0 = '0;
            if (key_t == '0)
                key_t = now;
            if (code != seen_code)
            begin
                lift_t0   = now;
                seen_code = code;
            end
            else if (lift_t0 != '0 && since_lift > time_t'(kp_deb))
            begin
                // release settled: current key becomes the last key
                lift_t0 = '0;
                last_ch = key_chan;
                last_t  = key_t;
                key_on  = 1'b0;
                key_t   = now;
            end
        end
        r.key_channel = key_chan;
        r.key_valid   = key_on;
        r.key_time    = key_t;
        key_expect_q.push_back(r);
    endfunction

    // Write one register while the block is idle
    task automatic write_setting(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_KEYPAD_LOCK:    kp_lock = value[0];
            CFG_NONE_THRESHOLD: kp_thr  = value[7:0];
            CFG_DEBOUNCE_MS:    kp_deb  = value[7:0];
            CFG_REPEAT_GAP_MS:  kp_gap  = value;
            default:            ;
        endcase
        settings_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_scan(input time_t stamp, input logic [7:0] code);
        scan_item_t s;
        s.stamp = stamp;
        s.code  = code;
        pending_scans.push_back(s);
        queued++;
    endtask

    function automatic logic [7:0] pick_touch();
        return 8'($urandom_range(0, kp_thr - 1));
    endfunction

    function automatic logic [7:0] pick_none();
        return 8'($urandom_range(kp_thr, 255));
    endfunction

    // Mostly long enough to settle, sometimes a bounce that falls short
    function automatic int unsigned pick_span();
        if ($urandom_range(0, 99) < 80)
            return kp_deb + $urandom_range(1, kp_deb / 2 + 6);
        return $urandom_range(0, kp_deb);
    endfunction

    // Hold one code for a span of milliseconds, with the odd glitch scan
    task automatic hold_code(input logic [7:0] code, input int unsigned span);
        int unsigned gone;
        int unsigned step;
        gone = 0;
        do
        begin
            add_scan(clock_ms, code);
            if ($urandom_range(0, 15) == 0)
                add_scan(clock_ms, 8'($urandom_range(0, 255)));
            step = $urandom_range(0, kp_deb / 4 + 2);
            clock_ms += step;
            gone += step;
        end
        while (gone <= span);
    endtask

    // Keystrokes with random content, mixed with bounces, noise and wrap jumps
    task automatic random_keystrokes(input int upto);
        int         pick;
        logic [7:0] ch;
        while (queued < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if ($urandom_range(0, 1) == 1 && last_touch < kp_thr)
                    ch = last_touch;
                else
                    ch = pick_touch();
                last_touch = ch;
                if ($urandom_range(0, 99) < 30)
                    clock_ms += $urandom_range(0, 2 * kp_gap + 20);
                hold_code(ch, pick_span());
                hold_code(pick_none(), pick_span());
            end
            else if (pick < 88)
                hold_code(8'($urandom_range(0, 255)), $urandom_range(0, kp_deb));
            else if (pick < 96)
            begin
                add_scan($urandom(), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                    clock_ms = $urandom();
            end
            else
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * kp_deb + 20);
        end
    endtask

    // Wait until every scan is taken and every key item has come back
    task automatic settle();
        while (pending_scans.size() != 0 || key_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Scan driver: offer the head of the queue, drop it once taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_bus.valid      <= 1'b0;
            scan_bus.now_ms     <= '0;
            scan_bus.touch_code <= '0;
        end
        else
        begin
            if (scan_bus.valid && scan_bus.ready)
            begin
                keypad_step(scan_bus.now_ms, scan_bus.touch_code);
                void'(pending_scans.pop_front());
                scans_taken++;
            end
            if (!scan_bus.valid || scan_bus.ready)
            begin
                if (pending_scans.size() != 0 &&
                    ((scans_taken >= CALM_FROM && scans_taken < CALM_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    scan_bus.valid      <= 1'b1;
                    scan_bus.now_ms     <= pending_scans[0].stamp;
                    scan_bus.touch_code <= pending_scans[0].code;
                end
                else
                    scan_bus.valid <= 1'b0;
            end
        end
    end

    // Key monitor: check each item against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bus.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (key_bus.valid && key_bus.ready)
            begin
                if (key_expect_q.size() == 0)
                begin
                    $display("%0t: key item with nothing expected: channel %0d valid %0b time %0d",
                             $time, key_bus.key_channel, key_bus.key_valid, key_bus.key_time);
                    mismatches++;
                end
                else
                begin
                    want = key_expect_q.pop_front();
                    if (key_bus.key_channel !== want.key_channel)
                    begin
                        $display("%0t: key_channel expected %0d, got %0d",
                                 $time, want.key_channel, key_bus.key_channel);
                        mismatches++;
                    end
                    if (key_bus.key_valid !== want.key_valid)
                    begin
                        $display("%0t: key_valid expected %0b, got %0b",
                                 $time, want.key_valid, key_bus.key_valid);
                        mismatches++;
                    end
                    if (key_bus.key_time !== want.key_time)
                    begin
                        $display("%0t: key_time expected %0d, got %0d",
                                 $time, want.key_time, key_bus.key_time);
                        mismatches++;
                    end
                end
                results_taken++;
                if (key_bus.key_valid === 1'b1)
                    keys_held++;
            end
            // hold off once for a long stretch so the block backs up
            if (hold_left != 0)
            begin
                hold_left--;
                key_bus.ready <= 1'b0;
            end
            else if (!hold_done && results_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                key_bus.ready <= 1'b0;
            end
            else
                key_bus.ready <= (results_taken >= CALM_FROM && results_taken < CALM_TO) ||
                                 $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (scan_bus.valid && scan_bus.ready) || (key_bus.valid && key_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d scans and %0d key items outstanding",
                     $time, quiet_cycles, pending_scans.size(), key_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus: directed scans, then random phases under several settings
    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // first scan with no touch, empty key time, release without a press
        add_scan(32'd0, 8'd20);
        add_scan(32'd3, 8'd20);
        add_scan(32'd5, 8'd30);
        add_scan(32'd16, 8'd30);
        // zero time stamp cannot start timing
        add_scan(32'd0, 8'd5);
        add_scan(32'd4, 8'd5);
        // press channel 0, release through code 0xFF
        add_scan(32'd6, 8'd0);
        add_scan(32'd17, 8'd0);
        add_scan(32'd20, 8'hFF);
        add_scan(32'd31, 8'hFF);
        // same channel again inside the repeat gap is refused
        add_scan(32'd40, 8'd0);
        add_scan(32'd51, 8'd0);
        add_scan(32'd60, 8'd0);
        // top channel below threshold, exactly at debounce then just over
        add_scan(32'd100, 8'd12);
        add_scan(32'd110, 8'd12);
        add_scan(32'd111, 8'd12);
        add_scan(32'd120, 8'd13);
        add_scan(32'd131, 8'd13);
        // same channel once the repeat gap has passed
        add_scan(32'd300, 8'd12);
        add_scan(32'd400, 8'd12);
        // release and press across the time wrap
        add_scan(32'hFFFF_FFF8, 8'd200);
        add_scan(32'h0000_0003, 8'd200);
        add_scan(32'hFFFF_FFFF, 8'd7);
        add_scan(32'd10, 8'd7);
        clock_ms = 32'd20;
        random_keystrokes(330);
        settle();

        // widest threshold, no debounce, no repeat gap
        write_setting(CFG_NONE_THRESHOLD, 16'd255);
        write_setting(CFG_DEBOUNCE_MS, 16'd0);
        write_setting(CFG_REPEAT_GAP_MS, 16'd0);
        random_keystrokes(480);
        settle();

        // single channel, longest debounce and repeat gap
        write_setting(CFG_NONE_THRESHOLD, 16'd1);
        write_setting(CFG_DEBOUNCE_MS, 16'd255);
        write_setting(CFG_REPEAT_GAP_MS, 16'hFFFF);
        random_keystrokes(620);
        settle();

        // keypad locked
        write_setting(CFG_KEYPAD_LOCK, 16'd1);
        write_setting(CFG_NONE_THRESHOLD, 16'd20);
        write_setting(CFG_DEBOUNCE_MS, 16'd5);
        random_keystrokes(700);
        settle();

        // unlocked again with random settings
        write_setting(CFG_KEYPAD_LOCK, 16'd0);
        write_setting(CFG_NONE_THRESHOLD, 16'($urandom_range(2, 254)));
        write_setting(CFG_DEBOUNCE_MS, 16'($urandom_range(0, 60)));
        write_setting(CFG_REPEAT_GAP_MS, 16'($urandom_range(0, 600)));
        random_keystrokes(860);
        settle();

        $display("Scans taken: %0d over %0d register writes (defaults, extremes, locked).",
                 scans_taken, settings_used);
        $display("Key items checked: %0d, %0d with a key held, %0d mismatches.",
                 results_taken, keys_held, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
